// ----- rtl/lzw_pkg.sv -----
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared constants, payload types and controller/datapath command types for
// the LZW byte compressor.
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int ROOT_CODES   = 256;
    localparam int CODE_W       = $clog2(DICT_ENTRIES);
    localparam int NEXT_W       = CODE_W + 1;
    localparam int OUT_CODE_W   = 16;
    localparam int NODE_W       = CODE_W + 8;
    localparam int OFIFO_DEPTH  = 2;
    localparam int OFIFO_PTR_W  = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W  = $clog2(OFIFO_DEPTH + 1);

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] code;
        logic                  end_of_stream;
    } t_out;

    typedef struct packed {
        logic capture;
        logic first;
        logic head;
        logic walk;
        logic hit;
        logic add1;
        logic add2;
        logic restart;
        logic push_miss;
        logic push_final;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic prefix_valid;
        logic last;
        logic head_zero;
        logic match;
        logic sib_zero;
        logic full;
    } t_dp_sts;

endpackage

// ----- rtl/lzw_ram.sv -----
// ----------------------------------------------------------------------------
// lzw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/lzw_ofifo.sv -----
// ----------------------------------------------------------------------------
// lzw_ofifo
// Two-entry result queue; decouples code emission from the output stall.
// ----------------------------------------------------------------------------
module lzw_ofifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzw_pkg::t_out i_push_data,
    output logic          o_space,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lzw_pkg::t_out o_out_data
);
    import lzw_pkg::*;

    t_out                   r_mem [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] r_wr_ptr;
    logic [OFIFO_PTR_W-1:0] r_rd_ptr;
    logic [OFIFO_CNT_W-1:0] r_count;
    logic                   pop;

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign o_space     = (r_count != OFIFO_CNT_W'(OFIFO_DEPTH));
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OFIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OFIFO_PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + OFIFO_CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - OFIFO_CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/lzw_dp.sv -----
// ----------------------------------------------------------------------------
// lzw_dp
// Datapath: prefix and next-code registers, root child valid bits, child
// and node (sibling, byte) RAMs, sibling-chain compare.
// ----------------------------------------------------------------------------
module lzw_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lzw_pkg::t_in     i_in_data,
    input  lzw_pkg::t_dp_cmd i_cmd,
    output lzw_pkg::t_dp_sts o_sts,
    output logic             o_push,
    output lzw_pkg::t_out    o_push_data
);
    import lzw_pkg::*;

    logic [7:0]      r_byte;
    logic            r_last;
    t_code           r_prefix;
    logic            r_pv;
    logic [NEXT_W-1:0] r_next;
    t_code           r_node;
    t_code           r_head;
    logic            r_root_vld [ROOT_CODES];

    t_code           child_rd;
    logic [NODE_W-1:0] node_rd;
    t_code           node_sib;
    logic [7:0]      node_byte;
    t_code           head_comb;
    logic            prefix_is_root;
    logic            full;
    t_code           next_addr;

    logic            child_we;
    t_code           child_waddr;
    t_code           child_wdata;
    t_code           node_raddr;

    assign next_addr      = r_next[CODE_W-1:0];
    assign full           = (r_next == NEXT_W'(DICT_ENTRIES));
    assign prefix_is_root = (r_prefix[CODE_W-1:8] == '0);
    assign head_comb      = (prefix_is_root && !r_root_vld[r_prefix[7:0]]) ? '0 : child_rd;
    assign node_sib       = node_rd[NODE_W-1:8];
    assign node_byte      = node_rd[7:0];

    assign node_raddr  = i_cmd.walk ? node_sib : head_comb;
    assign child_we    = i_cmd.add1 || i_cmd.add2;
    assign child_waddr = i_cmd.add1 ? r_prefix : next_addr;
    assign child_wdata = i_cmd.add1 ? next_addr : '0;

    lzw_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DICT_ENTRIES)
    ) u_child_ram (
        .i_clk     (i_clk),
        .i_wr_en   (child_we),
        .i_wr_addr (child_waddr),
        .i_wr_data (child_wdata),
        .i_rd_addr (r_prefix),
        .o_rd_data (child_rd)
    );

    lzw_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DICT_ENTRIES)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.add1),
        .i_wr_addr (next_addr),
        .i_wr_data ({r_head, r_byte}),
        .i_rd_addr (node_raddr),
        .o_rd_data (node_rd)
    );

    assign o_sts.prefix_valid = r_pv;
    assign o_sts.last         = r_last;
    assign o_sts.head_zero    = (head_comb == '0);
    assign o_sts.match        = (node_byte == r_byte);
    assign o_sts.sib_zero     = (node_sib == '0);
    assign o_sts.full         = full;

    assign o_push                    = i_cmd.push_miss || i_cmd.push_final;
    assign o_push_data.code          = OUT_CODE_W'(r_prefix);
    assign o_push_data.end_of_stream = i_cmd.push_final;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_in_data.data_byte;
            r_last <= i_in_data.last_byte;
        end
        if (i_cmd.head) begin
            r_head <= head_comb;
            r_node <= head_comb;
        end else if (i_cmd.walk) begin
            r_node <= node_sib;
        end
        if (i_cmd.first || i_cmd.add2 || i_cmd.restart) begin
            r_prefix <= CODE_W'(r_byte);
        end else if (i_cmd.hit) begin
            r_prefix <= r_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_next <= NEXT_W'(ROOT_CODES);
            for (int i = 0; i < ROOT_CODES; i++) begin
                r_root_vld[i] <= 1'b0;
            end
        end else if (i_cmd.clear) begin
            r_pv   <= 1'b0;
            r_next <= NEXT_W'(ROOT_CODES);
            for (int i = 0; i < ROOT_CODES; i++) begin
                r_root_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.first) begin
                r_pv <= 1'b1;
            end
            if (i_cmd.add1 && prefix_is_root) begin
                r_root_vld[r_prefix[7:0]] <= 1'b1;
            end
            if (i_cmd.add2) begin
                r_next <= r_next + NEXT_W'(1);
            end
        end
    end

    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next >= NEXT_W'(ROOT_CODES)) && (r_next <= NEXT_W'(DICT_ENTRIES)))
        else $error("next code out of range");

    a_add_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add1 |-> !full)
        else $error("entry added to full dictionary");

    a_add_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add1 |=> i_cmd.add2)
        else $error("child link write not followed by node init");

    a_prefix_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (NEXT_W'(r_prefix) < r_next))
        else $error("prefix code not yet allocated");

endmodule

// ----- rtl/lzw_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzw_ctrl
// Controller: sequences lookup through the child/sibling chain, emission,
// dictionary insertion and end-of-stream handling for one byte at a time.
// ----------------------------------------------------------------------------
module lzw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  lzw_pkg::t_dp_sts i_sts,
    input  logic             i_space,
    output lzw_pkg::t_dp_cmd o_cmd
);
    import lzw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CHILD,
        S_WALK,
        S_MISS,
        S_ADD2,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state done_state;

    assign o_in_stall = (r_state != S_IDLE);
    assign done_state = i_sts.last ? S_FINAL : S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_sts.prefix_valid) begin
                    o_cmd.first = 1'b1;
                    n_state     = done_state;
                end else begin
                    n_state = S_CHILD;
                end
            end
            S_CHILD: begin
                o_cmd.head = 1'b1;
                n_state    = i_sts.head_zero ? S_MISS : S_WALK;
            end
            S_WALK: begin
                if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = done_state;
                end else if (i_sts.sib_zero) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_MISS: begin
                if (i_space) begin
                    o_cmd.push_miss = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.restart = 1'b1;
                        n_state       = done_state;
                    end else begin
                        o_cmd.add1 = 1'b1;
                        n_state    = S_ADD2;
                    end
                end
            end
            S_ADD2: begin
                o_cmd.add2 = 1'b1;
                n_state    = done_state;
            end
            S_FINAL: begin
                if (i_space) begin
                    o_cmd.push_final = 1'b1;
                    o_cmd.clear      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/lzw_byte_compressor_top.sv -----
// Steps: a stream's first byte becomes the prefix; a later byte reads the child head
// and compares chain nodes in turn: a hit takes the node as prefix, a miss emits the
// prefix and adds an entry (once full, restarts instead); a last byte adds the final code.
// A full result queue holds emission. One byte at a time, stalled until idle again.
// Reset (synchronous, active low) empties the dictionary and result queue;
// dictionary RAMs need no clearing pass and the block is ready at once.
// ----------------------------------------------------------------------------
// lzw_byte_compressor_top
// LZW byte stream compressor with a bounded dictionary held as a child /
// sibling tree in RAM.
// ----------------------------------------------------------------------------
module lzw_byte_compressor_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lzw_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lzw_pkg::t_out o_out_data
);
    import lzw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    space;
    logic    push;
    t_out    push_data;

    lzw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .i_space    (space),
        .o_cmd      (cmd)
    );

    lzw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_push      (push),
        .o_push_data (push_data)
    );

    lzw_ofifo u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
